### rtl/assert_macros.svh
// Assertion macros for the checker file of the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk and disabled during reset.
`define PMDF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pmdf assertion failed");

// Next-cycle implication, clocked on clk and disabled during reset.
`define PMDF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pmdf assertion failed");

`endif

### rtl/pmdf_pkg.sv
// Package of constants, codes and types for the pilot mix decimating FIR.
package pmdf_pkg;

    localparam int DEF_MAX_TAPS    = 128;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int OUT_BITS        = 32;
    localparam int COEF_INDEX_BITS = 7;
    localparam int DEC_BITS        = 7;
    localparam int TAPS_BITS       = 8;
    localparam int PHASE_BITS      = 6;
    localparam int MAX_DEC         = 64;

    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = 8;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_DECIMATION = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TAPS       = 2'd1;

    localparam logic [DEC_BITS-1:0]  DEC_RESET  = 7'd10;
    localparam logic [TAPS_BITS-1:0] TAPS_RESET = 8'd128;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_LOAD   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_PUSH  = 4'b0010,
        ST_MAC   = 4'b0100,
        ST_DRAIN = 4'b1000
    } pmdf_state_t;

endpackage

### rtl/pmdf_if.sv
// Channel interfaces: input items, result items and configuration writes.
interface pmdf_in_if
    import pmdf_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
    logic                              valid;
    logic                              ready;
    logic                              kind;
    logic signed [SAMPLE_BITS-1:0]     signal_re;
    logic signed [SAMPLE_BITS-1:0]     signal_im;
    logic signed [SAMPLE_BITS-1:0]     pilot_re;
    logic signed [SAMPLE_BITS-1:0]     pilot_im;
    logic        [COEF_INDEX_BITS-1:0] coef_index;
    logic signed [SAMPLE_BITS-1:0]     coef_re;
    logic signed [SAMPLE_BITS-1:0]     coef_im;

    modport source (
        output valid, kind, signal_re, signal_im, pilot_re, pilot_im,
               coef_index, coef_re, coef_im,
        input  ready
    );
    modport sink (
        input  valid, kind, signal_re, signal_im, pilot_re, pilot_im,
               coef_index, coef_re, coef_im,
        output ready
    );
endinterface

interface pmdf_out_if
    import pmdf_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [OUT_BITS-1:0] filtered_value;

    modport source (output valid, filtered_value, input ready);
    modport sink (input valid, filtered_value, output ready);
endinterface

interface pmdf_cfg_if
    import pmdf_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/pilot_mix_decimating_fir_core.sv
// Top level: pilot mixer, product history memory and decimating complex FIR.
//
// Channels (valid/ready, an item moves when both are high):
//   cfg     - register writes, index 0 decimation factor, 1 taps in use.
//             Always ready; write only while the block is idle.
//   samples - kind 0 carries a signal and a pilot sample, kind 1 loads one
//             complex coefficient. Load every tap in use before samples.
//   results - one filtered value on every decimation_factor-th sample,
//             starting with the first sample after reset.
// One item at a time: a load leaves the block idle for the next item; a
// sample that emits nothing passes through the push state only; an
// emitting sample then runs the MAC and drain states, with the history
// and coefficient memories each giving one tap per cycle to a
// three-stage multiply-accumulate pipeline.
// The result sits in an output register, so the next item is accepted
// while it waits; a finished sum only stalls if the previous result is
// still held by the receiver.
// Reset empties the history through a fill count (no clearing pass) and
// restores factor 10 and 128 taps; coefficients are left unwritten.
module pilot_mix_decimating_fir_core
    import pmdf_pkg::*;
#(
    parameter int MAX_TAPS    = DEF_MAX_TAPS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  logic       clk,
    input  logic       rst_n,
    pmdf_cfg_if.sink   cfg,
    pmdf_in_if.sink    samples,
    pmdf_out_if.source results
);

    localparam int SB     = SAMPLE_BITS;
    localparam int HW     = SB + 2;
    localparam int CW     = $clog2(MAX_TAPS + 1);
    localparam int AW     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int PROD_W = SB + HW;
    localparam int ACC_W  = PROD_W + 2 + AW;
    localparam int EXT_W  = (ACC_W > OUT_BITS + 1) ? ACC_W : OUT_BITS + 1;

    localparam logic signed [EXT_W-1:0] SAT_HI =
        {{(EXT_W-OUT_BITS+1){1'b0}}, {(OUT_BITS-1){1'b1}}};
    localparam logic signed [EXT_W-1:0] SAT_LO =
        {{(EXT_W-OUT_BITS+1){1'b1}}, {(OUT_BITS-1){1'b0}}};

    // history entry is {im, re}, coefficient entry is {im, re}
    logic [2*HW-1:0] hist_mem [MAX_TAPS];
    logic [2*SB-1:0] coef_mem [MAX_TAPS];

    pmdf_state_t state_reg;
    pmdf_state_t state_next;

    logic [DEC_BITS-1:0]   dec_reg;
    logic [TAPS_BITS-1:0]  taps_reg;
    logic [PHASE_BITS-1:0] phase_reg;
    logic [AW-1:0]         head_reg;
    logic [CW-1:0]         fill_reg;
    logic [CW-1:0]         tap_cnt_reg;
    logic [AW-1:0]         rd_ptr_reg;

    logic                    s1_v_reg;
    logic                    s1_hv_reg;
    logic                    s2_v_reg;
    logic [2*HW-1:0]         hist_q_reg;
    logic [2*SB-1:0]         coef_q_reg;
    logic signed [PROD_W-1:0] mul_re_reg;
    logic signed [PROD_W-1:0] mul_im_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic                      out_valid_reg;
    logic signed [OUT_BITS-1:0] out_data_reg;

    logic                    in_acc;
    logic                    is_load;
    logic                    coef_hit;
    logic [AW-1:0]           coef_addr;
    logic [AW-1:0]           head_dec;
    logic [DEC_BITS-1:0]     fac;
    logic [PHASE_BITS:0]     phase_inc;
    logic [PHASE_BITS-1:0]   phase_next;
    logic                    emit;
    logic [CW-1:0]           taps_eff;
    logic                    last_tap;
    logic                    drain_done;
    logic                    out_free;
    logic signed [HW-1:0]    mix_re;
    logic signed [HW-1:0]    mix_im;
    logic signed [HW-1:0]    h_re;
    logic signed [HW-1:0]    h_im;
    logic signed [SB-1:0]    c_re;
    logic signed [SB-1:0]    c_im;
    logic signed [ACC_W-1:0] acc_rnd;
    logic signed [EXT_W-1:0] acc_ext;
    logic signed [OUT_BITS-1:0] sat_val;

    pmdf_mixer #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mixer (
        .clk       (clk),
        .load      (in_acc && !is_load),
        .signal_re (samples.signal_re),
        .signal_im (samples.signal_im),
        .pilot_re  (samples.pilot_re),
        .pilot_im  (samples.pilot_im),
        .mix_re    (mix_re),
        .mix_im    (mix_im)
    );

    assign cfg.ready       = 1'b1;
    assign samples.ready   = (state_reg == ST_IDLE);
    assign results.valid   = out_valid_reg;
    assign results.filtered_value = out_data_reg;

    always_comb
    begin
        in_acc    = samples.valid && samples.ready;
        is_load   = (samples.kind == KIND_LOAD);
        coef_hit  = (int'(samples.coef_index) < MAX_TAPS);
        coef_addr = AW'(samples.coef_index);

        head_dec = (head_reg == '0) ? AW'(MAX_TAPS - 1) : head_reg - AW'(1);

        if (dec_reg == '0)
            fac = DEC_BITS'(1);
        else if (int'(dec_reg) > MAX_DEC)
            fac = DEC_BITS'(MAX_DEC);
        else
            fac = dec_reg;

        phase_inc  = {1'b0, phase_reg} + (PHASE_BITS+1)'(1);
        phase_next = (phase_inc >= fac) ? '0 : phase_inc[PHASE_BITS-1:0];
        emit       = (phase_reg == '0);

        if (taps_reg == '0)
            taps_eff = CW'(1);
        else if (int'(taps_reg) > MAX_TAPS)
            taps_eff = CW'(MAX_TAPS);
        else
            taps_eff = CW'(taps_reg);

        last_tap   = (tap_cnt_reg == taps_eff - CW'(1));
        drain_done = !s1_v_reg && !s2_v_reg;
        out_free   = !out_valid_reg || results.ready;

        // history entries older than the fill count read as zero
        h_re = s1_hv_reg ? hist_q_reg[HW-1:0]    : '0;
        h_im = s1_hv_reg ? hist_q_reg[2*HW-1:HW] : '0;
        c_re = coef_q_reg[SB-1:0];
        c_im = coef_q_reg[2*SB-1:SB];

        acc_rnd = (acc_reg + ACC_W'(1)) >>> 1;
        acc_ext = EXT_W'(acc_rnd);
        if (acc_ext > SAT_HI)
            sat_val = SAT_HI[OUT_BITS-1:0];
        else if (acc_ext < SAT_LO)
            sat_val = SAT_LO[OUT_BITS-1:0];
        else
            sat_val = acc_ext[OUT_BITS-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && !is_load)
                    state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                state_next = emit ? ST_MAC : ST_IDLE;
            end
            ST_MAC:
            begin
                if (last_tap)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (drain_done && out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // coefficient memory: written by load items, read one tap per cycle
    always_ff @(posedge clk)
    begin
        if (in_acc && is_load && coef_hit)
            coef_mem[coef_addr] <= {samples.coef_im, samples.coef_re};
        if (state_reg == ST_MAC)
            coef_q_reg <= coef_mem[tap_cnt_reg[AW-1:0]];
    end

    // history memory: newest product written below the old head
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_PUSH)
            hist_mem[head_dec] <= {mix_im, mix_re};
        if (state_reg == ST_MAC)
            hist_q_reg <= hist_mem[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (s1_v_reg)
        begin
            mul_re_reg <= c_re * h_re;
            mul_im_reg <= c_im * h_im;
        end
        if (state_reg == ST_DRAIN && drain_done && out_free)
            out_data_reg <= sat_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dec_reg       <= DEC_RESET;
            taps_reg      <= TAPS_RESET;
            phase_reg     <= '0;
            head_reg      <= '0;
            fill_reg      <= '0;
            tap_cnt_reg   <= '0;
            rd_ptr_reg    <= '0;
            s1_v_reg      <= 1'b0;
            s1_hv_reg     <= 1'b0;
            s2_v_reg      <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg.valid)
            begin
                case (cfg.index)
                    CFG_DECIMATION: dec_reg  <= cfg.data[DEC_BITS-1:0];
                    CFG_TAPS:       taps_reg <= cfg.data[TAPS_BITS-1:0];
                    default:        ;
                endcase
            end

            if (state_reg == ST_PUSH)
            begin
                head_reg  <= head_dec;
                phase_reg <= phase_next;
                if (fill_reg != CW'(MAX_TAPS))
                    fill_reg <= fill_reg + CW'(1);
                tap_cnt_reg <= '0;
                rd_ptr_reg  <= head_dec;
                acc_reg     <= '0;
            end

            if (state_reg == ST_MAC)
            begin
                tap_cnt_reg <= tap_cnt_reg + CW'(1);
                rd_ptr_reg  <= (rd_ptr_reg == AW'(MAX_TAPS - 1)) ? '0
                                                                 : rd_ptr_reg + AW'(1);
            end

            s1_v_reg  <= (state_reg == ST_MAC);
            s1_hv_reg <= (tap_cnt_reg < fill_reg);
            s2_v_reg  <= s1_v_reg;

            if (s2_v_reg)
                acc_reg <= acc_reg + ACC_W'(mul_re_reg) - ACC_W'(mul_im_reg);

            if (state_reg == ST_DRAIN && drain_done && out_free)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

### rtl/pmdf_mixer.sv
// Complex mixer: signal times pilot, registered products, rounded to Q3.15.
module pmdf_mixer
    import pmdf_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  logic                          clk,
    input  logic                          load,
    input  logic signed [SAMPLE_BITS-1:0] signal_re,
    input  logic signed [SAMPLE_BITS-1:0] signal_im,
    input  logic signed [SAMPLE_BITS-1:0] pilot_re,
    input  logic signed [SAMPLE_BITS-1:0] pilot_im,
    output logic signed [SAMPLE_BITS+1:0] mix_re,
    output logic signed [SAMPLE_BITS+1:0] mix_im
);

    localparam int PP_W  = 2 * SAMPLE_BITS;
    localparam int SUM_W = PP_W + 1;

    // half an output LSB, added before the floor shift
    localparam logic signed [SUM_W-1:0] HALF =
        {{(SAMPLE_BITS+2){1'b0}}, 1'b1, {(SAMPLE_BITS-2){1'b0}}};

    logic signed [PP_W-1:0]  pp_rr_reg;
    logic signed [PP_W-1:0]  pp_ii_reg;
    logic signed [PP_W-1:0]  pp_ri_reg;
    logic signed [PP_W-1:0]  pp_ir_reg;
    logic signed [SUM_W-1:0] re_sum;
    logic signed [SUM_W-1:0] im_sum;
    logic signed [SUM_W-1:0] re_shift;
    logic signed [SUM_W-1:0] im_shift;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pp_rr_reg <= signal_re * pilot_re;
            pp_ii_reg <= signal_im * pilot_im;
            pp_ri_reg <= signal_re * pilot_im;
            pp_ir_reg <= signal_im * pilot_re;
        end
    end

    always_comb
    begin
        re_sum   = SUM_W'(pp_rr_reg) - SUM_W'(pp_ii_reg) + HALF;
        im_sum   = SUM_W'(pp_ri_reg) + SUM_W'(pp_ir_reg) + HALF;
        re_shift = re_sum >>> (SAMPLE_BITS - 1);
        im_shift = im_sum >>> (SAMPLE_BITS - 1);
        mix_re   = re_shift[SAMPLE_BITS+1:0];
        mix_im   = im_shift[SAMPLE_BITS+1:0];
    end

endmodule

### rtl/pmdf_checker.sv
// Port-level checker for the pilot mix decimating FIR, bound to the top level.
`include "assert_macros.svh"

module pmdf_checker
    import pmdf_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic in_kind,
    input logic out_valid,
    input logic out_ready
);

    logic in_acc;

    assign in_acc = in_valid && in_ready;

    // a stalled result stays offered
    `PMDF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

    // one item at a time: once a sample is taken, the input is no longer ready
    `PMDF_ASSERT_NEXT(a_sample_busy, clk, rst_n, in_acc && in_kind == KIND_SAMPLE, !in_ready)

    // a coefficient load never produces a result
    `PMDF_ASSERT_NEXT(a_load_quiet, clk, rst_n,
        in_acc && in_kind == KIND_LOAD && !out_valid, !out_valid)

    // results appear only at the end of a filter pass, never from idle
    `PMDF_ASSERT_SAME(a_out_from_pass, clk, rst_n, $rose(out_valid), $past(!in_ready))

endmodule

bind pilot_mix_decimating_fir_core pmdf_checker u_pmdf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .in_kind   (samples.kind),
    .out_valid (results.valid),
    .out_ready (results.ready)
);

### tb/sv/tb_pilot_mix_decimating_fir_core.sv
// Self-checking bench for the pilot mix decimating FIR: predicts each filtered output.
module tb_pilot_mix_decimating_fir_core;
    import pmdf_pkg::*;

    localparam int SB       = DEF_SAMPLE_BITS;
    localparam int TAPS_MAX = DEF_MAX_TAPS;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_B = 2'd3;

    localparam logic signed [SB-1:0] Q_MAX  = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] Q_MIN  = {1'b1, {(SB-1){1'b0}}};
    localparam logic signed [SB-1:0] Q_ZERO = '0;

    localparam longint OUT_MAX = 64'sd2147483647;
    localparam longint OUT_MIN = -64'sd2147483648;

    localparam int HOLD_CYCLES = 600;
    localparam int DRAIN_GUARD = 500000;

    typedef struct {
        logic                        kind;
        logic signed [SB-1:0]        signal_re;
        logic signed [SB-1:0]        signal_im;
        logic signed [SB-1:0]        pilot_re;
        logic signed [SB-1:0]        pilot_im;
        logic [COEF_INDEX_BITS-1:0]  coef_index;
        logic signed [SB-1:0]        coef_re;
        logic signed [SB-1:0]        coef_im;
    } feed_item_t;

    logic clk;
    logic rst_n;

    pmdf_in_if #(.SAMPLE_BITS(SB)) feed_ch ();
    pmdf_out_if                    result_ch ();
    pmdf_cfg_if                    cfg_ch ();

    pilot_mix_decimating_fir_core #(
        .MAX_TAPS    (TAPS_MAX),
        .SAMPLE_BITS (SB)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .samples (feed_ch),
        .results (result_ch)
    );

    feed_item_t          feed_queue[$];
    feed_item_t          feed_now;
    logic [OUT_BITS-1:0] filtered_due[$];

    // mirror of the block: registers, mixed-product history, coefficients
    logic [DEC_BITS-1:0]  dec_reg;
    logic [TAPS_BITS-1:0] taps_reg;
    longint mix_re[TAPS_MAX];
    longint mix_im[TAPS_MAX];
    longint tap_re[TAPS_MAX];
    longint tap_im[TAPS_MAX];
    int     head;
    int     dec_phase;

    bit no_gaps;
    bit hold_armed;
    int hold_left;

    int samples_seen;
    int loads_seen;
    int outputs_checked;
    int saturated_seen;
    int reg_writes;
    int mismatches;
    int strays;

    function automatic longint round_half_up(input longint v, input int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic void mix_filter_step(input feed_item_t it);
        longint acc;
        int     fac;
        int     ntaps;
        int     k;
        bit     emit;
        if (it.kind == KIND_LOAD)
        begin
            tap_re[it.coef_index] = longint'(it.coef_re);
            tap_im[it.coef_index] = longint'(it.coef_im);
            loads_seen++;
            return;
        end
        samples_seen++;
        head = (head + TAPS_MAX - 1) % TAPS_MAX;
        mix_re[head] = round_half_up(longint'(it.signal_re) * it.pilot_re
                                     - longint'(it.signal_im) * it.pilot_im, SB - 1);
        mix_im[head] = round_half_up(longint'(it.signal_re) * it.pilot_im
                                     + longint'(it.signal_im) * it.pilot_re, SB - 1);
        fac = int'(dec_reg);
        if (fac < 1)
            fac = 1;
        if (fac > MAX_DEC)
            fac = MAX_DEC;
        emit = (dec_phase == 0);
        dec_phase = dec_phase + 1;
        if (dec_phase >= fac)
            dec_phase = 0;
        if (!emit)
            return;
        ntaps = int'(taps_reg);
        if (ntaps < 1)
            ntaps = 1;
        if (ntaps > TAPS_MAX)
            ntaps = TAPS_MAX;
        acc = 0;
        for (int j = 0; j < ntaps; j++)
        begin
            k = (head + j) % TAPS_MAX;
            acc += tap_re[j] * mix_re[k] - tap_im[j] * mix_im[k];
        end
        acc = round_half_up(acc, 1);
        if (acc > OUT_MAX)
            acc = OUT_MAX;
        if (acc < OUT_MIN)
            acc = OUT_MIN;
        filtered_due.push_back(acc[OUT_BITS-1:0]);
    endfunction

    // random Q1.15 value, scaled down by shift, with the rails now and then
    function automatic logic signed [SB-1:0] rand_q15(input int shift);
        logic [31:0]          r;
        logic signed [SB-1:0] v;
        r = $urandom;
        case (r[31:28])
            4'd0:    v = Q_MAX;
            4'd1:    v = Q_MIN;
            default:
            begin
                v = r[SB-1:0];
                v = v >>> shift;
            end
        endcase
        return v;
    endfunction

    task automatic push_sample(input logic signed [SB-1:0] sr, input logic signed [SB-1:0] si,
                               input logic signed [SB-1:0] pr, input logic signed [SB-1:0] pim);
        feed_item_t it;
        it.kind       = KIND_SAMPLE;
        it.signal_re  = sr;
        it.signal_im  = si;
        it.pilot_re   = pr;
        it.pilot_im   = pim;
        // coefficient fields are don't-care on samples
        it.coef_index = COEF_INDEX_BITS'($urandom_range(TAPS_MAX - 1));
        it.coef_re    = rand_q15(0);
        it.coef_im    = rand_q15(0);
        feed_queue.push_back(it);
    endtask

    task automatic push_load(input int idx, input logic signed [SB-1:0] cre,
                             input logic signed [SB-1:0] cim);
        feed_item_t it;
        it.kind       = KIND_LOAD;
        it.signal_re  = rand_q15(0);
        it.signal_im  = rand_q15(0);
        it.pilot_re   = rand_q15(0);
        it.pilot_im   = rand_q15(0);
        it.coef_index = COEF_INDEX_BITS'(idx);
        it.coef_re    = cre;
        it.coef_im    = cim;
        feed_queue.push_back(it);
    endtask

    task automatic feed_random(input int count, input int max_shift, input int load_pct);
        int sh;
        for (int i = 0; i < count; i++)
        begin
            sh = $urandom_range(max_shift);
            if ($urandom_range(99) < load_pct)
                push_load($urandom_range(TAPS_MAX - 1), rand_q15(sh), rand_q15(sh));
            else
                push_sample(rand_q15(sh), rand_q15(sh), rand_q15(sh), rand_q15(sh));
        end
    endtask

    // wait for every queued item to go in and every output to come out,
    // then give a trailing non-emitting item time to finish
    task automatic settle();
        int guard;
        guard = 0;
        do
        begin
            @(negedge clk);
            guard++;
        end
        while ((feed_queue.size() != 0 || feed_ch.valid || filtered_due.size() != 0)
               && guard < DRAIN_GUARD);
        repeat (TAPS_MAX + 20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_DECIMATION: dec_reg = val[DEC_BITS-1:0];
            CFG_TAPS:       taps_reg = val;
            default:        ;
        endcase
        reg_writes++;
    endtask

    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        feed_ch.valid    = 1'b0;
        feed_ch.kind     = KIND_SAMPLE;
        feed_ch.signal_re  = '0;
        feed_ch.signal_im  = '0;
        feed_ch.pilot_re   = '0;
        feed_ch.pilot_im   = '0;
        feed_ch.coef_index = '0;
        feed_ch.coef_re    = '0;
        feed_ch.coef_im    = '0;
        result_ch.ready  = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = CFG_DECIMATION;
        cfg_ch.data      = '0;
        forever #10 clk = ~clk;
    end

    // sender: holds each item until taken, idles at random between items
    always @(posedge clk or negedge rst_n)
    begin
        feed_item_t nxt;
        if (!rst_n)
        begin
            feed_ch.valid <= 1'b0;
        end
        else
        begin
            if (feed_ch.valid && feed_ch.ready)
                mix_filter_step(feed_now);
            if (!feed_ch.valid || feed_ch.ready)
            begin
                if (feed_queue.size() > 0 && (no_gaps || $urandom_range(99) >= 30))
                begin
                    nxt = feed_queue.pop_front();
                    feed_now = nxt;
                    feed_ch.valid      <= 1'b1;
                    feed_ch.kind       <= nxt.kind;
                    feed_ch.signal_re  <= nxt.signal_re;
                    feed_ch.signal_im  <= nxt.signal_im;
                    feed_ch.pilot_re   <= nxt.pilot_re;
                    feed_ch.pilot_im   <= nxt.pilot_im;
                    feed_ch.coef_index <= nxt.coef_index;
                    feed_ch.coef_re    <= nxt.coef_re;
                    feed_ch.coef_im    <= nxt.coef_im;
                end
                else
                begin
                    feed_ch.valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each output item, stalls at random or for a long hold
    always @(posedge clk or negedge rst_n)
    begin
        logic [OUT_BITS-1:0] want;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (filtered_due.size() == 0)
                begin
                    if (mismatches + strays < 10)
                        $display("output %0d arrived with none outstanding",
                                 $signed(result_ch.filtered_value));
                    strays++;
                end
                else
                begin
                    want = filtered_due.pop_front();
                    outputs_checked++;
                    if (want == OUT_MAX[OUT_BITS-1:0] || want == OUT_MIN[OUT_BITS-1:0])
                        saturated_seen++;
                    if (result_ch.filtered_value !== want)
                    begin
                        if (mismatches + strays < 10)
                            $display("filtered_value mismatch: expected %0d, got %0d",
                                     $signed(want), $signed(result_ch.filtered_value));
                        mismatches++;
                    end
                end
            end
            if (hold_armed)
            begin
                hold_left = HOLD_CYCLES;
                hold_armed = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= no_gaps || ($urandom_range(99) >= 30);
            end
        end
    end

    initial
    begin
        int leftover;
        int fac_data;
        int taps_data;

        dec_reg   = DEC_RESET;
        taps_reg  = TAPS_RESET;
        head      = 0;
        dec_phase = 0;
        for (int i = 0; i < TAPS_MAX; i++)
        begin
            mix_re[i] = 0;
            mix_im[i] = 0;
            tap_re[i] = 0;
            tap_im[i] = 0;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // full coefficient set first: reset taps read all of them;
        // lowest taps at the rails for the saturation cases
        for (int i = 0; i < TAPS_MAX; i++)
        begin
            if (i < 4)
                push_load(i, Q_MAX, Q_MIN);
            else if (i < 8)
                push_load(i, Q_MIN, Q_MAX);
            else
                push_load(i, rand_q15(0), rand_q15(0));
        end

        // reset settings: first sample emits against an all-zero history
        push_sample(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        push_sample(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        push_sample(Q_MIN, Q_MIN, Q_MIN, Q_MAX);
        push_sample(Q_MAX, Q_MAX, Q_MIN, Q_MAX);
        push_sample(Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO);
        feed_random(6, 0, 0);
        settle();

        // one output per sample over four rail-valued taps: both limits
        write_reg(CFG_DECIMATION, 8'd1);
        write_reg(CFG_TAPS, 8'd4);
        repeat (4) push_sample(Q_MIN, Q_MIN, Q_MIN, Q_MAX);
        repeat (4) push_sample(Q_MAX, Q_MAX, Q_MIN, Q_MAX);
        push_load(0, Q_ZERO, Q_MIN);
        push_sample(Q_MAX, Q_MIN, Q_MAX, Q_MIN);
        push_sample(Q_ZERO, Q_MAX, Q_MIN, Q_ZERO);
        settle();

        // long receiver hold with the sender pushing flat out
        no_gaps = 1'b1;
        hold_armed = 1'b1;
        feed_random(200, 4, 10);
        settle();
        no_gaps = 1'b0;

        // above-range factor and taps clamp to 64 and 128
        write_reg(CFG_DECIMATION, 8'hFF);
        write_reg(CFG_TAPS, 8'hFF);
        feed_random(150, 3, 8);
        settle();

        // zero factor and taps count as one; small coefficients keep sums in range
        write_reg(CFG_DECIMATION, 8'd0);
        write_reg(CFG_TAPS, 8'd0);
        for (int i = 0; i < TAPS_MAX; i++)
            push_load(i, rand_q15(6), rand_q15(6));
        feed_random(150, 8, 10);
        settle();

        write_reg(CFG_SPARE_A, 8'h01);
        write_reg(CFG_SPARE_B, 8'hFF);
        write_reg(CFG_DECIMATION, 8'd64);
        write_reg(CFG_TAPS, 8'd129);
        feed_random(150, 6, 10);
        settle();

        // top bit of the data is dropped, leaving factor zero
        write_reg(CFG_DECIMATION, 8'h80);
        write_reg(CFG_TAPS, 8'd128);
        feed_random(75, 8, 10);
        settle();
        feed_random(75, 8, 10);
        settle();

        for (int p = 0; p < 7; p++)
        begin
            if ($urandom_range(3) == 0)
                fac_data = $urandom_range(255);
            else
                fac_data = $urandom_range(1, 12);
            if ($urandom_range(9) < 6)
                taps_data = $urandom_range(1, 32);
            else
                taps_data = $urandom_range(255);
            write_reg(CFG_DECIMATION, fac_data[CFG_DATA_BITS-1:0]);
            write_reg(CFG_TAPS, taps_data[CFG_DATA_BITS-1:0]);
            if (p == 3)
                no_gaps = 1'b1;
            feed_random($urandom_range(60, 100), $urandom_range(8), 10);
            if ($urandom_range(1) == 0)
                settle();
            feed_random($urandom_range(60, 100), $urandom_range(8), 10);
            settle();
            no_gaps = 1'b0;
        end

        settle();
        leftover = filtered_due.size();
        if (leftover != 0)
            $display("%0d filtered outputs never arrived", leftover);
        $display("Fed %0d samples and %0d coefficient loads across %0d register writes;",
                 samples_seen, loads_seen, reg_writes);
        $display("checked %0d filtered outputs, %0d of them clipped at a rail.",
                 outputs_checked, saturated_seen);
        if (mismatches == 0 && strays == 0 && leftover == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // a correct run finishes long before this timeout
    initial
    begin
        #(20 * 2000000);
        $display("run timed out");
        $display("Some tests failed");
        $finish;
    end

endmodule
